[rtl/spm_pkg.sv]
// ----------------------------------------------------------------------------
// spm_pkg
// Shared constants for the stream pattern masker: register map, field widths
// and the replacement byte.
// ----------------------------------------------------------------------------
package spm_pkg;

    // Default and largest pattern length
    localparam int PATTERN_MAX_DEF = 16;

    // Results one request may cause, at most
    localparam int OUT_MAX = 16;

    // Configuration port geometry (64-bit registers at 8-byte spacing)
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;
    localparam int LEN_W      = 5;

    // Register indexes
    localparam logic [1:0] REG_PAT_LO  = 2'd0;
    localparam logic [1:0] REG_PAT_HI  = 2'd1;
    localparam logic [1:0] REG_PAT_LEN = 2'd2;

    // Byte that replaces every matched byte
    localparam logic [7:0] STAR_BYTE = 8'h2A;

endpackage

[rtl/stream_pattern_masker.sv]
// ----------------------------------------------------------------------------
// stream_pattern_masker
// Replaces each leftmost, non-overlapping pattern match in a byte stream by '*'.
// A result passes through the input register, then the result buffer, before it
// can be taken.
// Throughput: one input per cycle while each input causes at most one result and
// the output is not stalled; an input causing N > 1 results holds the input side until its run drains.
// Reset: synchronous, active low; clears window fill, valid state and config.
// ----------------------------------------------------------------------------
module stream_pattern_masker #(
    parameter int PATTERN_MAX = spm_pkg::PATTERN_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    input  logic                           s_axis_tlast,   // is_final
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] out_byte
    output logic                           m_axis_tlast,   // run_last
    output logic [0:0]                     m_axis_tuser,   // [0] stream_done
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spm_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import spm_pkg::*;

    localparam int CW = $clog2(PATTERN_MAX + 2);   // counts up to PATTERN_MAX + 1
    localparam int OW = $clog2(OUT_MAX + 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [APB_DATA_W-1:0] r_pat_lo;
    logic [APB_DATA_W-1:0] r_pat_hi;
    logic [LEN_W-1:0]      r_len;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_fin;

    logic [7:0]            r_win [PATTERN_MAX];
    logic [CW-1:0]         r_fill;

    logic [7:0]            r_obuf [OUT_MAX];
    logic [OW-1:0]         r_ocnt;
    logic                  r_ofin;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic [2*APB_DATA_W-1:0] w_pat_all;
    logic [7:0]              w_pat  [PATTERN_MAX];
    logic [CW-1:0]           w_len;
    logic [CW-1:0]           w_keep;
    logic [7:0]              w_ext  [PATTERN_MAX + 1];   // window plus new byte
    logic [CW-1:0]           w_pre;                      // bytes popped first
    logic [CW-1:0]           w_rem;
    logic                    w_full;
    logic [7:0]              w_cmp  [PATTERN_MAX];       // window aligned at w_pre
    logic                    w_eq;
    logic                    w_match;
    logic [CW-1:0]           w_emit;                     // bytes leaving the window
    logic [CW-1:0]           w_total;
    logic [CW:0]             w_star_end;
    logic [OW-1:0]           n_ocnt;
    logic [7:0]              n_obuf [OUT_MAX];
    logic [7:0]              n_win  [PATTERN_MAX];
    logic [CW-1:0]           n_fill;
    logic                    w_in_take;
    logic                    w_out_take;
    logic                    w_load_ok;
    logic                    w_load;
    logic                    w_cfg_wr;
    logic [1:0]              w_cfg_idx;

    // Pattern bytes, byte 0 lowest
    assign w_pat_all = {r_pat_hi, r_pat_lo};
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            w_pat[i] = w_pat_all[8*i +: 8];
        end
    end

    // Effective length, saturated to PATTERN_MAX
    always_comb begin
        if (int'(r_len) > PATTERN_MAX) begin
            w_len = CW'(PATTERN_MAX);
        end else begin
            w_len = CW'(r_len);
        end
        w_keep = (w_len == '0) ? '0 : w_len - CW'(1);
    end

    // Window extended by the new byte
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            w_ext[k] = (CW'(k) < r_fill) ? r_win[k] : r_in_byte;
        end
        w_ext[PATTERN_MAX] = r_in_byte;
    end

    // Pops forced by a shortened length, then the fill check
    always_comb begin
        w_pre  = (r_fill > w_keep) ? r_fill - w_keep : '0;
        w_rem  = r_fill - w_pre + CW'(1);
        w_full = (w_len != '0) && (w_rem == w_len);
    end

    // Align the window at the first byte that stays, compare with pattern
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            w_cmp[i] = w_ext[i];
            for (int s = 0; s <= PATTERN_MAX - i; s++) begin
                if (w_pre == CW'(s)) begin
                    w_cmp[i] = w_ext[i + s];
                end
            end
        end
        w_eq = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if ((CW'(i) < w_len) && (w_cmp[i] != w_pat[i])) begin
                w_eq = 1'b0;
            end
        end
        w_match = w_full && w_eq;
    end

    // Number of bytes that leave the window, and results to deliver
    always_comb begin
        priority if (w_len == '0) begin
            w_emit = r_fill + CW'(1);
        end else if (!w_full) begin
            w_emit = w_pre;
        end else if (w_match) begin
            w_emit = w_pre + w_len;
        end else begin
            w_emit = w_pre + CW'(1);
        end
        w_total = r_in_fin ? r_fill + CW'(1) : w_emit;
        if (int'(w_total) > OUT_MAX) begin
            n_ocnt = OW'(OUT_MAX);
        end else begin
            n_ocnt = OW'(w_total);
        end
        w_star_end = {1'b0, w_pre} + {1'b0, w_len};
    end

    // Result bytes: extended window with the matched span as stars
    always_comb begin
        for (int j = 0; j < OUT_MAX; j++) begin
            n_obuf[j] = '0;
            if (j <= PATTERN_MAX) begin
                if (w_match && (int'(w_pre) <= j) && (j < int'(w_star_end))) begin
                    n_obuf[j] = STAR_BYTE;
                end else begin
                    n_obuf[j] = w_ext[j];
                end
            end
        end
    end

    // Window after this request
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            n_win[k] = w_ext[k];
            for (int s = 0; s <= PATTERN_MAX - k; s++) begin
                if (w_emit == CW'(s)) begin
                    n_win[k] = w_ext[k + s];
                end
            end
        end
        n_fill = r_in_fin ? '0 : r_fill + CW'(1) - w_emit;
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign w_out_take    = m_axis_tvalid && m_axis_tready;
    assign w_load_ok     = (r_ocnt == '0) || ((r_ocnt == OW'(1)) && m_axis_tready);
    assign w_load        = r_in_valid && w_load_ok;
    assign s_axis_tready = !r_in_valid || w_load_ok;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid   = (r_ocnt != '0);
    assign m_axis_tdata    = r_obuf[0];
    assign m_axis_tlast    = (r_ocnt == OW'(1));
    assign m_axis_tuser[0] = (r_ocnt == OW'(1)) && r_ofin;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_take) begin
            r_in_byte <= s_axis_tdata;
            r_in_fin  <= s_axis_tlast;
        end
    end

    // Window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_load) begin
            r_fill <= n_fill;
        end
        if (w_load) begin
            r_win <= n_win;
        end
    end

    // Result buffer: load a run, then shift one byte per delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= '0;
        end else if (w_load) begin
            r_ocnt <= n_ocnt;
        end else if (w_out_take) begin
            r_ocnt <= r_ocnt - OW'(1);
        end
        if (w_load) begin
            r_obuf <= n_obuf;
            r_ofin <= r_in_fin;
        end else if (w_out_take) begin
            for (int j = 0; j < OUT_MAX - 1; j++) begin
                r_obuf[j] <= r_obuf[j + 1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[APB_ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_len    <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_PAT_LO:  r_pat_lo <= pwdata;
                REG_PAT_HI:  r_pat_hi <= pwdata;
                REG_PAT_LEN: r_len    <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_PAT_LO:  prdata = r_pat_lo;
            REG_PAT_HI:  prdata = r_pat_hi;
            REG_PAT_LEN: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, r_len};
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // window fill stays below PATTERN_MAX between requests
    a_fill_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) < PATTERN_MAX)
        else $error("window fill reached pattern length");

    // no new request enters while one is held and a multi-byte run is draining
    a_hold_on_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_ocnt > OW'(1))) |-> !s_axis_tready)
        else $error("input taken during a pending run");

    // a stalled result keeps its run count
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (r_ocnt == $past(r_ocnt)))
        else $error("result run changed while stalled");

    // result run never exceeds the buffer depth
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_ocnt) <= OUT_MAX)
        else $error("result run too long");

endmodule
